[rtl/core/cft_pkg.sv]
// Shared types and constants for the CSV field tokenizer.
package cft_pkg;

  // Text bytes with a fixed meaning
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // Quote tracking codes
  localparam logic [1:0] QS_OUT   = 2'd0;
  localparam logic [1:0] QS_IN    = 2'd1;
  localparam logic [1:0] QS_QUOTE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DELIM   = 1'b0;
  localparam logic CFG_COMMENT = 1'b1;

  // Which result of the current item goes out
  typedef enum logic [2:0] {
    SEG_SPACE = 3'd0,
    SEG_BYTE  = 3'd1,
    SEG_EFA   = 3'd2,
    SEG_EFB   = 3'd3,
    SEG_ROW   = 3'd4
  } seg_t;

  // Results still owed for one item, in output order
  typedef struct packed {
    logic flush;
    logic byte_en;
    logic efa;
    logic efb;
  } plan_t;

  typedef struct packed {
    plan_t nx;          // plan of the item offered on the input
    plan_t cur;         // plan of the item being emitted
    logic  flush_last;  // last pending whitespace byte is selected
    logic  out_free;    // output register can take a result
  } status_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic last;
    seg_t seg;
  } cmd_t;

endpackage

[rtl/core/cft_datapath.sv]
// Tokenizer datapath: parse state, pending whitespace store, plan and output register.
module cft_datapath #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       in_byte,
  input  logic             in_end,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  cft_pkg::cmd_t    cmd,
  output cft_pkg::status_t st,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,  // byte_value[7:0], was_quoted[8], whitespace_overflow[9]
  output logic [1:0]       m_tuser,  // kind[1:0]
  output logic             m_tlast
);
  import cft_pkg::*;

  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(PENDING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(PENDING_DEPTH);

  // configuration
  logic [7:0] delimiter;
  logic [7:0] comment_char;

  // parse state
  logic [1:0]    quote_state, quote_state_next;
  logic          raw_nonempty, raw_nonempty_next;
  logic          field_quoted, field_quoted_next;
  logic          has_content, has_content_next;
  logic          row_started, row_started_next;
  logic          first_field, first_field_next;
  logic          comment_row, comment_row_next;
  logic [CW-1:0] space_count, space_count_next;
  logic          overflow, overflow_next;

  // pending whitespace store: 1 marks a tab
  logic          space_mem [PENDING_DEPTH];
  logic          space_rd;
  logic [IW-1:0] fidx, fidx_next;

  // plan of the item in flight
  plan_t         plan, plan_next;
  logic [CW-1:0] flush_n;
  logic [7:0]    byte_val;
  logic          efa_q, efa_ov, efb_q, efb_ov;
  logic          efb_q_next, efb_ov_next;

  logic          mem_we;

  always_comb begin
    logic outside, a_push, push_en, is_q, blank, hold, store, ovf, emit_b;
    logic flush_do, open_q, is_delim, is_nl, b_push, efa_ev, row_nl, eot_row;
    logic rs1, fq1, ov1, cr1, fhc1, rfn1, supp;
    logic [1:0] qs1;
    logic [CW-1:0] cnt1;

    is_q    = (in_byte == CH_QUOTE);
    outside = 1'b1;
    a_push  = 1'b0;
    qs1     = QS_OUT;
    unique case (quote_state)
      QS_QUOTE: begin
        if (is_q) begin
          a_push  = 1'b1;
          qs1     = QS_IN;
          outside = 1'b0;
        end
      end
      QS_IN: begin
        outside = 1'b0;
        if (is_q) qs1 = QS_QUOTE;
        else begin
          a_push = 1'b1;
          qs1    = QS_IN;
        end
      end
      default: qs1 = QS_OUT;
    endcase

    open_q   = outside && is_q && !raw_nonempty;
    is_delim = outside && !open_q && (in_byte == delimiter);
    is_nl    = outside && !open_q && !is_delim && (in_byte == CH_LF || in_byte == CH_CR);
    b_push   = outside && !open_q && !is_delim && !is_nl;
    push_en  = a_push || b_push;

    // leading and trailing blank handling for unquoted fields
    blank    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    hold     = push_en && !field_quoted && blank;
    store    = hold && has_content && (space_count < DEPTH_C);
    ovf      = hold && has_content && !(space_count < DEPTH_C);
    emit_b   = push_en && !hold;
    flush_do = emit_b && !field_quoted && has_content && (space_count != '0);

    rfn1 = raw_nonempty || push_en;
    rs1  = row_started || push_en || open_q || is_delim;
    fhc1 = has_content || emit_b;
    fq1  = field_quoted || open_q;
    ov1  = overflow || ovf;
    cr1  = comment_row || (emit_b && !has_content && first_field &&
                           comment_char != CH_NUL && in_byte == comment_char);
    if (store) cnt1 = space_count + CW'(1);
    else if (emit_b && !field_quoted && has_content) cnt1 = '0;
    else cnt1 = space_count;
    if (open_q) qs1 = QS_IN;

    efa_ev  = is_delim;
    row_nl  = is_nl && row_started;
    eot_row = in_end && (row_nl ? 1'b0 : rs1);
    supp    = cr1;

    mem_we = cmd.load && store;

    plan_next.flush   = flush_do && !supp;
    plan_next.byte_en = emit_b && !supp;
    plan_next.efa     = efa_ev && !supp;
    plan_next.efb     = (row_nl || eot_row) && !supp;
    efb_q_next  = efa_ev ? 1'b0 : fq1;
    efb_ov_next = efa_ev ? 1'b0 : ov1;

    quote_state_next  = qs1;
    raw_nonempty_next = rfn1;
    field_quoted_next = fq1;
    has_content_next  = fhc1;
    row_started_next  = rs1;
    first_field_next  = first_field;
    comment_row_next  = cr1;
    space_count_next  = cnt1;
    overflow_next     = ov1;
    if (in_end) begin
      quote_state_next  = QS_OUT;
      raw_nonempty_next = 1'b0;
      field_quoted_next = 1'b0;
      has_content_next  = 1'b0;
      row_started_next  = 1'b0;
      first_field_next  = 1'b1;
      comment_row_next  = 1'b0;
      space_count_next  = '0;
      overflow_next     = 1'b0;
    end else if (row_nl || efa_ev) begin
      raw_nonempty_next = 1'b0;
      field_quoted_next = 1'b0;
      has_content_next  = 1'b0;
      space_count_next  = '0;
      overflow_next     = 1'b0;
      row_started_next  = efa_ev;
      first_field_next  = row_nl;
      comment_row_next  = row_nl ? 1'b0 : cr1;
    end
  end

  always_comb begin
    if (cmd.load) fidx_next = '0;
    else if (cmd.emit && cmd.seg == SEG_SPACE && fidx != LAST_IDX) fidx_next = fidx + IW'(1);
    else fidx_next = fidx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) space_mem[space_count[IW-1:0]] <= (in_byte == CH_TAB);
    space_rd <= space_mem[fidx_next];
    fidx     <= fidx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter    <= 8'd44;
      comment_char <= CH_NUL;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DELIM) delimiter <= cfg_data;
      else comment_char <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_state  <= QS_OUT;
      raw_nonempty <= 1'b0;
      field_quoted <= 1'b0;
      has_content  <= 1'b0;
      row_started  <= 1'b0;
      first_field  <= 1'b1;
      comment_row  <= 1'b0;
      space_count  <= '0;
      overflow     <= 1'b0;
      plan         <= '0;
    end else if (cmd.load) begin
      quote_state  <= quote_state_next;
      raw_nonempty <= raw_nonempty_next;
      field_quoted <= field_quoted_next;
      has_content  <= has_content_next;
      row_started  <= row_started_next;
      first_field  <= first_field_next;
      comment_row  <= comment_row_next;
      space_count  <= space_count_next;
      overflow     <= overflow_next;
      plan         <= plan_next;
    end
  end

  // payload of the plan; field flags for a delimiter come from the pre-item state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flush_n  <= space_count;
      byte_val <= in_byte;
      efa_q    <= field_quoted;
      efa_ov   <= overflow;
      efb_q    <= efb_q_next;
      efb_ov   <= efb_ov_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.last;
      case (cmd.seg)
        SEG_SPACE: begin
          m_tuser <= KIND_DATA;
          m_tdata <= {8'd0, space_rd ? CH_TAB : CH_SPACE};
        end
        SEG_BYTE: begin
          m_tuser <= KIND_DATA;
          m_tdata <= {8'd0, byte_val};
        end
        SEG_EFA: begin
          m_tuser <= KIND_FIELD;
          m_tdata <= {6'd0, efa_ov, efa_q, 8'd0};
        end
        SEG_EFB: begin
          m_tuser <= KIND_FIELD;
          m_tdata <= {6'd0, efb_ov, efb_q, 8'd0};
        end
        default: begin
          m_tuser <= KIND_ROW;
          m_tdata <= 16'd0;
        end
      endcase
    end
  end

  assign st.nx         = plan_next;
  assign st.cur        = plan;
  assign st.flush_last = ((CW'(fidx) + CW'(1)) == flush_n);
  assign st.out_free   = !m_tvalid || m_tready;

endmodule

[rtl/core/cft_ctrl.sv]
// Tokenizer controller: steps through the results owed for one accepted byte.
module cft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  cft_pkg::status_t st,
  output cft_pkg::cmd_t    cmd
);
  import cft_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SPACE = 6'b000010,
    S_BYTE  = 6'b000100,
    S_EFA   = 6'b001000,
    S_EFB   = 6'b010000,
    S_ROW   = 6'b100000
  } state_t;

  state_t state, state_next;

  function automatic state_t first_seg(plan_t f);
    if (f.flush) return S_SPACE;
    else if (f.byte_en) return S_BYTE;
    else if (f.efa) return S_EFA;
    else if (f.efb) return S_EFB;
    else return S_IDLE;
  endfunction

  always_comb begin
    plan_t rest;
    rest       = st.cur;
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = first_seg(st.nx);
        end
      end
      S_SPACE: begin
        cmd.seg = SEG_SPACE;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          rest.flush = 1'b0;
          if (st.flush_last) state_next = first_seg(rest);
        end
      end
      S_BYTE: begin
        cmd.seg = SEG_BYTE;
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          rest.flush   = 1'b0;
          rest.byte_en = 1'b0;
          state_next   = first_seg(rest);
        end
      end
      S_EFA: begin
        cmd.seg = SEG_EFA;
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          rest.flush   = 1'b0;
          rest.byte_en = 1'b0;
          rest.efa     = 1'b0;
          state_next   = first_seg(rest);
        end
      end
      S_EFB: begin
        cmd.seg = SEG_EFB;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.seg = SEG_ROW;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.last = cmd.emit && (state_next == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free) else $error("result issued into a full output register");
  a_space_planned: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPACE) |-> st.cur.flush) else $error("whitespace flush without a plan");
  a_row_planned: assert property (@(posedge clk) disable iff (rst)
    (state == S_EFB) |-> st.cur.efb) else $error("row end without a plan");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE)) else $error("last result but still busy");
`endif

endmodule

[rtl/core/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer.
// Order: an accepted byte's plan is registered first; its results then enter the output register in turn.
// Throughput: a new byte is taken only in the idle state, after every result (0 to 19) of the last one;
//   the output register sends at most one result per cycle, fewer while m_tready holds it, and each pending
//   blank flushed from the whitespace store is sent as a result of its own.
// Reset (rst, synchronous): parse state cleared, delimiter 44, comment byte 0;
//   the whitespace store is not cleared.
module csv_field_tokenizer #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // byte_value[7:0], was_quoted[8], whitespace_overflow[9]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import cft_pkg::*;

  status_t st;
  cmd_t    cmd;

  assign cfg_ready = 1'b1;

  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cft_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[verif/csv_field_tokenizer_tb.sv]
// Self-checking testbench for the CSV field tokenizer: streamed text, predicted tokens.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
  import cft_pkg::*;

  localparam int PEND_DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_CYCLES = 400;
  localparam int STALL_AT_ITEM = 60;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic       quoted;
    logic       ovf;
    logic       is_last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DELIM;
  logic [7:0]  cfg_data = '0;

  text_item_t text_q[$];
  text_item_t draft_q[$];
  token_t     tokens_due[$];
  token_t     step_tokens[$];

  bit calm = 1'b0;
  int accepted_items = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // tokenizer shadow state
  logic [1:0]  qs;
  bit          raw_nonempty, fld_quoted, fld_content, row_open, first_fld, cm_row, blank_ovf;
  bit          blank_tab [PEND_DEPTH];
  int unsigned blank_cnt;
  logic [7:0]  delim_reg, cmt_reg;

  csv_field_tokenizer #(.PENDING_DEPTH(PEND_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------- prediction ----------------

  task automatic clear_parse();
    qs = QS_OUT;
    raw_nonempty = 1'b0;
    fld_quoted = 1'b0;
    fld_content = 1'b0;
    row_open = 1'b0;
    first_fld = 1'b1;
    cm_row = 1'b0;
    blank_cnt = 0;
    blank_ovf = 1'b0;
  endtask

  // comment rows are parsed but swallow all their output
  task automatic emit_token(input logic [1:0] k, input logic [7:0] v, input logic q,
                            input logic o);
    token_t t;
    if (!cm_row) begin
      t.kind = k;
      t.value = v;
      t.quoted = q;
      t.ovf = o;
      t.is_last = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
    end
  endtask

  task automatic take_byte(input logic [7:0] c);
    raw_nonempty = 1'b1;
    row_open = 1'b1;
    if (!fld_quoted) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        // leading blanks vanish, interior ones wait for a non-blank byte
        if (fld_content) begin
          if (blank_cnt < PEND_DEPTH) begin
            blank_tab[blank_cnt] = (c == CH_TAB);
            blank_cnt++;
          end else begin
            blank_ovf = 1'b1;
          end
        end
        return;
      end
      if (fld_content) begin
        for (int i = 0; i < blank_cnt; i++)
          emit_token(KIND_DATA, blank_tab[i] ? CH_TAB : CH_SPACE, 1'b0, 1'b0);
        blank_cnt = 0;
      end
    end
    if (!fld_content) begin
      fld_content = 1'b1;
      if (first_fld && cmt_reg != CH_NUL && c == cmt_reg)
        cm_row = 1'b1;
    end
    emit_token(KIND_DATA, c, 1'b0, 1'b0);
  endtask

  task automatic close_field();
    emit_token(KIND_FIELD, 8'h00, fld_quoted, blank_ovf);
    raw_nonempty = 1'b0;
    fld_quoted = 1'b0;
    fld_content = 1'b0;
    blank_cnt = 0;
    blank_ovf = 1'b0;
  endtask

  task automatic close_row();
    close_field();
    emit_token(KIND_ROW, 8'h00, 1'b0, 1'b0);
    row_open = 1'b0;
    first_fld = 1'b1;
    cm_row = 1'b0;
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eot);
    bit outside;
    token_t t;
    outside = 1'b1;
    step_tokens.delete();
    if (qs == QS_QUOTE) begin
      if (c == CH_QUOTE) begin
        take_byte(CH_QUOTE);
        qs = QS_IN;
        outside = 1'b0;
      end else begin
        qs = QS_OUT;
      end
    end else if (qs == QS_IN) begin
      if (c == CH_QUOTE)
        qs = QS_QUOTE;
      else
        take_byte(c);
      outside = 1'b0;
    end else begin
      qs = QS_OUT;
    end

    if (outside) begin
      if (c == CH_QUOTE && !raw_nonempty) begin
        qs = QS_IN;
        fld_quoted = 1'b1;
        row_open = 1'b1;
      end else if (c == delim_reg) begin
        row_open = 1'b1;
        close_field();
        first_fld = 1'b0;
      end else if (c == CH_LF || c == CH_CR) begin
        if (row_open)
          close_row();
      end else begin
        take_byte(c);
      end
    end

    if (eot) begin
      if (row_open)
        close_row();
      clear_parse();
    end

    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.is_last = (i == step_tokens.size() - 1);
      tokens_due.insert(tokens_due.size(), t);
    end
  endtask

  // ---------------- checking ----------------

  task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      $error("unexpected transaction: kind %0d byte %02h", m_tuser, m_tdata[7:0]);
      mismatches++;
      return;
    end
    want = tokens_due.pop_front();
    cmp_field("kind", 8'(want.kind), 8'(m_tuser));
    cmp_field("byte_value", want.value, m_tdata[7:0]);
    cmp_field("was_quoted", 8'(want.quoted), 8'(m_tdata[8]));
    cmp_field("whitespace_overflow", 8'(want.ovf), 8'(m_tdata[9]));
    cmp_field("last", 8'(want.is_last), 8'(m_tlast));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      delim_reg = ",";
      cmt_reg = CH_NUL;
    end else begin
      if (m_tvalid && m_tready)
        check_token();
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        accepted_items <= accepted_items + 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DELIM)
          delim_reg = cfg_data;
        else
          cmt_reg = cfg_data;
      end
    end
  end

  // ---------------- driver and sink ----------------

  always @(posedge clk) begin : feed
    text_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        it = text_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= it.ch;
        s_tlast <= it.eot;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // one long hold-off early on so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!stall_done && accepted_items >= STALL_AT_ITEM) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("csv_field_tokenizer_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_ch(input logic [7:0] b);
    draft_q.insert(draft_q.size(), text_item_t'{b, 1'b0});
  endtask

  task automatic add_blank();
    add_ch($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
  endtask

  function automatic logic [7:0] plain_ch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return 8'($urandom_range(0, 255));
    if (r < 70)
      return 8'($urandom_range("a", "z"));
    return 8'($urandom_range("0", "9"));
  endfunction

  task automatic gen_field(input logic [7:0] dl);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return;
    if (r < 45) begin
      add_ch(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0: begin
            add_ch(CH_QUOTE);
            add_ch(CH_QUOTE);
          end
          1: add_ch(dl);
          2: add_ch($urandom_range(0, 1) ? CH_CR : CH_LF);
          3: add_blank();
          default: add_ch(plain_ch());
        endcase
      end
      // most quoted fields close; a few run on as broken text
      if ($urandom_range(0, 99) < 88)
        add_ch(CH_QUOTE);
      if ($urandom_range(0, 99) < 15)
        add_ch($urandom_range(0, 1) ? CH_SPACE : plain_ch());
    end else begin
      repeat ($urandom_range(0, 2)) add_blank();
      repeat ($urandom_range(1, 5)) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          repeat ($urandom_range(14, 20)) add_blank();
        else if (r < 18)
          repeat ($urandom_range(1, 3)) add_blank();
        else if (r < 23)
          add_ch(CH_QUOTE);
        add_ch(plain_ch());
      end
      if ($urandom_range(0, 99) < 4)
        repeat ($urandom_range(16, 19)) add_blank();
      else
        repeat ($urandom_range(0, 2)) add_blank();
    end
  endtask

  task automatic gen_text(input logic [7:0] dl, input logic [7:0] cm, input int budget);
    int r;
    int nf;
    draft_q.delete();
    while (draft_q.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6))
          draft_q.insert(draft_q.size(),
                         text_item_t'{8'($urandom), $urandom_range(0, 9) == 0});
      end else if (r < 14) begin
        add_ch($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else begin
        if (cm != CH_NUL && $urandom_range(0, 4) == 0)
          add_ch(cm);
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
          if (f != 0)
            add_ch(dl);
          gen_field(dl);
        end
        case ($urandom_range(0, 4))
          0: add_ch(CH_LF);
          1: add_ch(CH_CR);
          2: begin
            add_ch(CH_CR);
            add_ch(CH_LF);
          end
          3: add_ch(CH_LF);
          default: ; // row runs into the next one
        endcase
      end
    end
    // keep each burst at its budget
    while (draft_q.size() > budget)
      draft_q.delete(draft_q.size() - 1);
    draft_q[draft_q.size() - 1].eot = 1'b1;
    foreach (draft_q[i])
      text_q.insert(text_q.size(), draft_q[i]);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (text_q.size() != 0 || s_tvalid || tokens_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    // doubled quote, quote inside plain field, text after closing quote,
    // quote after leading blank, trimmed tab, CR LF pair, end of text on closing quote
    logic [7:0] opening [$] = {CH_QUOTE, 8'hFF, CH_QUOTE, CH_QUOTE, "b", CH_QUOTE, ",",
                               "x", CH_QUOTE, CH_NUL, ",",
                               CH_QUOTE, "q", CH_QUOTE, "z", ",",
                               CH_SPACE, CH_QUOTE, "w", CH_TAB, CH_CR, CH_LF,
                               CH_QUOTE, "e", CH_QUOTE};
    logic [7:0] delims [9] = '{",", ";", CH_TAB, CH_QUOTE, CH_LF, CH_SPACE,
                               8'h00, 8'hFF, CH_CR};
    logic [7:0] comments [9] = '{"#", CH_NUL, 8'hFF, ";", CH_NUL, "#",
                                 CH_QUOTE, CH_SPACE, "a"};
    int lens [9] = '{60, 50, 35, 35, 35, 30, 30, 30, 30};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i])
      text_q.insert(text_q.size(), text_item_t'{opening[i], i == opening.size() - 1});

    for (int p = 0; p < 9; p++) begin
      wait_drained();
      write_reg(CFG_DELIM, delims[p]);
      write_reg(CFG_COMMENT, comments[p]);
      calm <= (p == 1);
      gen_text(delims[p], comments[p], lens[p]);
    end
    wait_drained();

    if (mismatches == 0)
      $display("csv_field_tokenizer_tb: done, clean");
    else
      $display("csv_field_tokenizer_tb: done, errors");
    $finish;
  end

endmodule
